// ===== rtl/spstk_pkg.sv =====
// Shared types and codes for the sparse pair store with ranked queries.
package spstk_pkg;

  localparam int KEY_W   = 16;
  localparam int VALUE_W = 32;
  localparam int TOTAL_W = 42;
  localparam int TOP_W   = 5;
  localparam int RANK_W  = 4;

  localparam logic [1:0] CMD_PUT       = 2'd0;
  localparam logic [1:0] CMD_QUERY_ROW = 2'd1;
  localparam logic [1:0] CMD_QUERY_COL = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;
  localparam logic [1:0] STATUS_EMPTY = 2'd3;

  localparam logic [1:0] CFG_ROWS    = 2'd0;
  localparam logic [1:0] CFG_COLUMNS = 2'd1;
  localparam logic [1:0] CFG_TOP     = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]   row;
    logic [KEY_W-1:0]   col;
    logic [VALUE_W-1:0] value;
  } entry_t;

endpackage

// ===== rtl/sparse_pair_store_top_k_top.sv =====
// Sparse pair store: put with replace, and ranked top-k row and column queries.
// With n the clamped top_count, a put scans every stored entry before it writes or reports
// a full store, and a valid query scans every stored entry and then emits n ranked results.
// Errors and empty-store answers skip the scan; result stalls add to the time of all of these.
// Items are taken one at a time. Synchronous reset clears the entry count, the ranked list
// and the control state and loads the register defaults; the entry memory is not cleared.
module sparse_pair_store_top_k_top
  import spstk_pkg::*;
#(
  parameter int CAPACITY = 1024,
  parameter int MAX_TOP  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         command,
  input  logic [KEY_W-1:0]   row_index,
  input  logic [KEY_W-1:0]   column_index,
  input  logic [VALUE_W-1:0] put_value,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         status,
  output logic [RANK_W-1:0]  rank,
  output logic [KEY_W-1:0]   ranked_key,
  output logic [VALUE_W-1:0] ranked_value,
  output logic [TOTAL_W-1:0] total,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [KEY_W-1:0]   cfg_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NW = $clog2(MAX_TOP + 1);
  localparam int TW = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_PUT_END = 3'd2;
  localparam logic [2:0] S_REPORT  = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;

  logic [KEY_W-1:0]   rows_in_use;
  logic [KEY_W-1:0]   columns_in_use;
  logic [TOP_W-1:0]   top_count;

  logic [2:0]         state;
  logic               is_put;
  logic               by_row;
  logic [KEY_W-1:0]   row_q;
  logic [KEY_W-1:0]   col_q;
  logic [VALUE_W-1:0] val_q;
  logic [NW-1:0]      n_q;
  logic [NW-1:0]      n_next;
  logic [CW-1:0]      count;
  logic [CW-1:0]      issue_cnt;
  logic               rd_vld;
  logic [AW-1:0]      rd_addr;
  logic               hit;
  logic [AW-1:0]      hit_addr;
  logic [TOTAL_W-1:0] sum_acc;
  logic [TOTAL_W:0]   sum_wide;
  logic [NW-1:0]      rank_cnt;
  logic [1:0]         report_status;

  logic [KEY_W-1:0]   slot_key [MAX_TOP];
  logic [VALUE_W-1:0] slot_val [MAX_TOP];
  logic [MAX_TOP-1:0] slot_vld;
  logic [MAX_TOP-1:0] beat;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  entry_t             ram_wdata;
  entry_t             rd_entry;

  logic               accept;
  logic               out_free;
  logic               row_ok;
  logic               col_ok;
  logic [KEY_W-1:0]   rd_match;
  logic [KEY_W-1:0]   rd_key;
  logic               rd_hit_query;
  logic               full;
  logic [TW-1:0]      emit_idx;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign row_ok     = (row_index != '0) && (row_index <= rows_in_use);
  assign col_ok     = (column_index != '0) && (column_index <= columns_in_use);
  assign full       = (count == CW'(CAPACITY));
  assign emit_idx   = rank_cnt[TW-1:0];

  always_comb begin
    if (top_count == '0) begin
      n_next = NW'(1);
    end else if (32'(top_count) > MAX_TOP) begin
      n_next = NW'(MAX_TOP);
    end else begin
      n_next = NW'(top_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use    <= '1;
      columns_in_use <= '1;
      top_count      <= TOP_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS:    rows_in_use    <= cfg_data;
        CFG_COLUMNS: columns_in_use <= cfg_data;
        CFG_TOP:     top_count      <= cfg_data[TOP_W-1:0];
        default:     ;
      endcase
    end
  end

  spstk_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(issue_cnt[AW-1:0]),
    .rdata(rd_entry)
  );

  always_comb begin
    ram_we          = (state == S_PUT_END) && (hit || !full);
    ram_waddr       = hit ? hit_addr : count[AW-1:0];
    ram_wdata.row   = row_q;
    ram_wdata.col   = col_q;
    ram_wdata.value = val_q;
  end

  assign rd_match     = by_row ? rd_entry.row : rd_entry.col;
  assign rd_key       = by_row ? rd_entry.col : rd_entry.row;
  assign rd_hit_query = (state == S_SCAN) && rd_vld && !is_put && (rd_match == (by_row ? row_q
                        : col_q));
  assign sum_wide     = {1'b0, sum_acc} + (TOTAL_W + 1)'(rd_entry.value);

  always_comb begin
    for (int k = 0; k < MAX_TOP; k++) begin
      beat[k] = slot_vld[k] && ((slot_val[k] > rd_entry.value) ||
                ((slot_val[k] == rd_entry.value) && (slot_key[k] < rd_key)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      slot_vld <= '0;
      rd_vld   <= 1'b0;
      hit      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            row_q     <= row_index;
            col_q     <= column_index;
            val_q     <= put_value;
            is_put    <= (command == CMD_PUT);
            by_row    <= (command == CMD_QUERY_ROW);
            n_q       <= n_next;
            issue_cnt <= '0;
            rd_vld    <= 1'b0;
            hit       <= 1'b0;
            sum_acc   <= '0;
            slot_vld  <= '0;
            case (command)
              CMD_PUT: begin
                if (row_ok && col_ok) begin
                  state <= S_SCAN;
                end else begin
                  report_status <= STATUS_RANGE;
                  state         <= S_REPORT;
                end
              end
              CMD_QUERY_ROW, CMD_QUERY_COL: begin
                if (!((command == CMD_QUERY_ROW) ? row_ok : col_ok)) begin
                  report_status <= STATUS_RANGE;
                  state         <= S_REPORT;
                end else if (count == '0) begin
                  report_status <= STATUS_EMPTY;
                  state         <= S_REPORT;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                report_status <= STATUS_RANGE;
                state         <= S_REPORT;
              end
            endcase
          end
        end
        S_SCAN: begin
          rd_vld <= (issue_cnt < count);
          if (issue_cnt < count) begin
            issue_cnt <= issue_cnt + CW'(1);
            rd_addr   <= issue_cnt[AW-1:0];
          end
          if (rd_vld && is_put && !hit && (rd_entry.row == row_q) &&
              (rd_entry.col == col_q)) begin
            hit      <= 1'b1;
            hit_addr <= rd_addr;
          end
          if (rd_hit_query) begin
            sum_acc <= sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
            for (int k = 0; k < MAX_TOP; k++) begin
              if ((NW'(k) < n_q) && !beat[k]) begin
                if ((k == 0) || beat[(k == 0) ? 0 : k - 1]) begin
                  slot_key[k] <= rd_key;
                  slot_val[k] <= rd_entry.value;
                  slot_vld[k] <= 1'b1;
                end else begin
                  slot_key[k] <= slot_key[(k == 0) ? 0 : k - 1];
                  slot_val[k] <= slot_val[(k == 0) ? 0 : k - 1];
                  slot_vld[k] <= slot_vld[(k == 0) ? 0 : k - 1];
                end
              end
            end
          end
          if ((issue_cnt == count) && !rd_vld) begin
            rank_cnt <= '0;
            state    <= is_put ? S_PUT_END : S_EMIT;
          end
        end
        S_PUT_END: begin
          if (!hit && !full) begin
            count <= count + CW'(1);
          end
          report_status <= (!hit && full) ? STATUS_FULL : STATUS_OK;
          state         <= S_REPORT;
        end
        S_REPORT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (rank_cnt == n_q - NW'(1)) begin
              state <= S_IDLE;
            end else begin
              rank_cnt <= rank_cnt + NW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free && ((state == S_REPORT) || (state == S_EMIT))) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && (state == S_REPORT)) begin
      status       <= report_status;
      rank         <= '0;
      ranked_key   <= '0;
      ranked_value <= '0;
      total        <= '0;
      last         <= 1'b1;
    end else if (out_free && (state == S_EMIT)) begin
      status       <= STATUS_OK;
      rank         <= RANK_W'(rank_cnt);
      ranked_key   <= slot_vld[emit_idx] ? slot_key[emit_idx] : '0;
      ranked_value <= slot_vld[emit_idx] ? slot_val[emit_idx] : '0;
      total        <= sum_acc;
      last         <= (rank_cnt == n_q - NW'(1));
    end
  end

endmodule

// ===== rtl/spstk_ram.sv =====
// Generic single-port-write, registered-read RAM.
module spstk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/spstk_checker.sv =====
// Port-level assertions for the sparse pair store, bound to its top level.
module spstk_checker
  import spstk_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic [1:0]         status,
  input logic [RANK_W-1:0]  rank,
  input logic [KEY_W-1:0]   ranked_key,
  input logic [VALUE_W-1:0] ranked_value,
  input logic [TOTAL_W-1:0] total,
  input logic               last
);

  // Items are processed one at a time, so a transfer is always followed by a stall.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input accepted twice in a row");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != STATUS_OK) |-> last)
    else $error("error result is not the last result");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != STATUS_OK) |-> (rank == '0) && (ranked_key == '0) &&
    (ranked_value == '0) && (total == '0))
    else $error("error result carries data");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(status) && $stable(rank) &&
    $stable(ranked_key) && $stable(ranked_value) && $stable(total) && $stable(last))
    else $error("stalled result changed");

endmodule

bind sparse_pair_store_top_k_top spstk_checker u_spstk_checker (.*);

// ===== tb/sparse_pair_store_top_k_top_tb.sv =====
// Self-checking testbench for the sparse pair store with ranked row and column queries.
module sparse_pair_store_top_k_top_tb;
  import spstk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = 1024;
  localparam int MAX_TOP     = 16;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE      = 64;
  localparam int REPORT_CAP  = 40;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [TOTAL_W:0] TOTAL_SAT = {1'b0, {TOTAL_W{1'b1}}};

  typedef struct {
    logic [1:0]         status;
    logic [RANK_W-1:0]  rank;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } answer_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               item_valid;
  logic               item_stall;
  logic [1:0]         command;
  logic [KEY_W-1:0]   row_index;
  logic [KEY_W-1:0]   column_index;
  logic [VALUE_W-1:0] put_value;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [1:0]         status;
  logic [RANK_W-1:0]  rank;
  logic [KEY_W-1:0]   ranked_key;
  logic [VALUE_W-1:0] ranked_value;
  logic [TOTAL_W-1:0] total;
  logic               last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [KEY_W-1:0]   cfg_data;

  logic [KEY_W-1:0]   store_row [CAPACITY];
  logic [KEY_W-1:0]   store_col [CAPACITY];
  logic [VALUE_W-1:0] store_val [CAPACITY];
  int                 stored_count = 0;
  logic [KEY_W-1:0]   max_row = 16'hFFFF;
  logic [KEY_W-1:0]   max_col = 16'hFFFF;
  logic [TOP_W-1:0]   top_n = 5'd16;

  answer_t owed_answers [$];
  bit      quiet = 1'b0;
  int      mismatch_count = 0;
  int      items_sent = 0;
  int      answers_checked = 0;
  int      reg_writes = 0;
  int      cycle_count = 0;

  sparse_pair_store_top_k_top #(
    .CAPACITY(CAPACITY),
    .MAX_TOP (MAX_TOP)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .command     (command),
    .row_index   (row_index),
    .column_index(column_index),
    .put_value   (put_value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .status      (status),
    .rank        (rank),
    .ranked_key  (ranked_key),
    .ranked_value(ranked_value),
    .total       (total),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               owed_answers.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    result_stall <= !quiet && ($urandom_range(0, 99) < 9);
  end

  task automatic owe_single(input logic [1:0] code);
    answer_t a;
    a.status = code;
    a.rank   = '0;
    a.key    = '0;
    a.value  = '0;
    a.total  = '0;
    a.last   = 1'b1;
    owed_answers.push_back(a);
  endtask

  task automatic predict_answers(input logic [1:0] cmd, input logic [KEY_W-1:0] r,
                                 input logic [KEY_W-1:0] c, input logic [VALUE_W-1:0] v);
    logic [KEY_W-1:0]   keys [MAX_TOP];
    logic [VALUE_W-1:0] vals [MAX_TOP];
    logic [TOTAL_W:0]   sum;
    logic [KEY_W-1:0]   idx, limit, match, key;
    logic               by_row, found;
    answer_t            a;
    int                 n, filled, i, j, k;
    case (cmd)
      CMD_PUT: begin
        if (r == 0 || r > max_row || c == 0 || c > max_col) begin
          owe_single(STATUS_RANGE);
        end else begin
          found = 1'b0;
          for (i = 0; i < stored_count; i++) begin
            if (!found && store_row[i] == r && store_col[i] == c) begin
              store_val[i] = v;
              found = 1'b1;
            end
          end
          if (found) begin
            owe_single(STATUS_OK);
          end else if (stored_count >= CAPACITY) begin
            owe_single(STATUS_FULL);
          end else begin
            store_row[stored_count] = r;
            store_col[stored_count] = c;
            store_val[stored_count] = v;
            stored_count++;
            owe_single(STATUS_OK);
          end
        end
      end
      CMD_QUERY_ROW, CMD_QUERY_COL: begin
        by_row = (cmd == CMD_QUERY_ROW);
        idx    = by_row ? r : c;
        limit  = by_row ? max_row : max_col;
        if (idx == 0 || idx > limit) begin
          owe_single(STATUS_RANGE);
        end else if (stored_count == 0) begin
          owe_single(STATUS_EMPTY);
        end else begin
          n = (top_n == 0) ? 1 : ((top_n > MAX_TOP) ? MAX_TOP : int'(top_n));
          for (j = 0; j < MAX_TOP; j++) begin
            keys[j] = '0;
            vals[j] = '0;
          end
          filled = 0;
          sum    = '0;
          for (i = 0; i < stored_count; i++) begin
            match = by_row ? store_row[i] : store_col[i];
            key   = by_row ? store_col[i] : store_row[i];
            if (match == idx) begin
              sum = sum + store_val[i];
              if (sum > TOTAL_SAT) sum = TOTAL_SAT;
              j = 0;
              while (j < filled && (vals[j] > store_val[i] ||
                     (vals[j] == store_val[i] && keys[j] < key))) j++;
              if (j < n) begin
                for (k = n - 1; k > j; k--) begin
                  keys[k] = keys[k-1];
                  vals[k] = vals[k-1];
                end
                keys[j] = key;
                vals[j] = store_val[i];
                if (filled < n) filled++;
              end
            end
          end
          for (j = 0; j < n; j++) begin
            a.status = STATUS_OK;
            a.rank   = j[RANK_W-1:0];
            a.key    = keys[j];
            a.value  = vals[j];
            a.total  = sum[TOTAL_W-1:0];
            a.last   = (j + 1 == n);
            owed_answers.push_back(a);
          end
        end
      end
      default: owe_single(STATUS_RANGE);
    endcase
  endtask

  task automatic check_field(input string what, input logic [TOTAL_W-1:0] want,
                             input logic [TOTAL_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (!rst && result_valid && !result_stall) begin
      if (owed_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
          $display("%0t: unexpected result, expected none, actual status %0d rank %0d",
                   $time, status, rank);
      end else begin
        want = owed_answers.pop_front();
        answers_checked++;
        check_field("status", want.status, status);
        check_field("rank", want.rank, rank);
        check_field("ranked_key", want.key, ranked_key);
        check_field("ranked_value", want.value, ranked_value);
        check_field("total", want.total, total);
        check_field("last", want.last, last);
      end
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [KEY_W-1:0] r,
                           input logic [KEY_W-1:0] c, input logic [VALUE_W-1:0] v);
    cfg_valid <= 1'b0;
    while (!quiet && $urandom_range(0, 99) < 9) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid   <= 1'b1;
    command      <= cmd;
    row_index    <= r;
    column_index <= c;
    put_value    <= v;
    do @(posedge clk); while (item_stall);
    predict_answers(cmd, r, c, v);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (owed_answers.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] which, input logic [KEY_W-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (which)
      CFG_ROWS:    max_row = data;
      CFG_COLUMNS: max_col = data;
      CFG_TOP:     top_n = data[TOP_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] tie_prone_value();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      1:       return VALUE_W'($urandom_range(0, 3)) << 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_and_errors();
    send_item(CMD_QUERY_ROW, 16'd1, 16'd7, 32'h0);
    send_item(CMD_QUERY_COL, 16'd3, 16'hFFFF, 32'h0);
    send_item(CMD_QUERY_ROW, 16'd0, 16'd1, 32'h0);
    send_item(CMD_QUERY_COL, 16'd1, 16'd0, 32'h0);
    send_item(CMD_UNKNOWN, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(CMD_PUT, 16'd0, 16'd5, 32'h100);
    send_item(CMD_PUT, 16'd5, 16'd0, 32'h100);
  endtask

  task automatic test_put_and_rank();
    send_item(CMD_PUT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(CMD_PUT, 16'd1, 16'd1, 32'h0);
    send_item(CMD_PUT, 16'd1, 16'd2, 32'h100);
    send_item(CMD_PUT, 16'd1, 16'd3, 32'h100);
    send_item(CMD_PUT, 16'd1, 16'd4, 32'h8000_0000);
    send_item(CMD_PUT, 16'd1, 16'd2, 32'h200);
    send_item(CMD_PUT, 16'd2, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(CMD_QUERY_ROW, 16'd1, 16'd0, 32'h0);
    send_item(CMD_QUERY_COL, 16'd0, 16'hFFFF, 32'h0);
    send_item(CMD_QUERY_ROW, 16'd3, 16'd0, 32'h0);
    send_item(CMD_QUERY_ROW, 16'hFFFF, 16'd0, 32'h0);
  endtask

  task automatic test_register_limits();
    write_reg(CFG_ROWS, 16'd1);
    write_reg(CFG_COLUMNS, 16'd1);
    send_item(CMD_PUT, 16'd2, 16'd1, 32'h300);
    send_item(CMD_PUT, 16'd1, 16'd2, 32'h300);
    send_item(CMD_QUERY_ROW, 16'd2, 16'd1, 32'h0);
    send_item(CMD_QUERY_COL, 16'd1, 16'd1, 32'h0);
    send_item(CMD_QUERY_COL, 16'd1, 16'd2, 32'h0);
    write_reg(CFG_ROWS, 16'hFFFF);
    write_reg(CFG_COLUMNS, 16'hFFFF);
  endtask

  task automatic test_top_count_bounds();
    write_reg(CFG_TOP, 16'd0);
    send_item(CMD_QUERY_ROW, 16'd1, 16'd0, 32'h0);
    write_reg(CFG_TOP, 16'd31);
    send_item(CMD_QUERY_ROW, 16'd1, 16'd0, 32'h0);
    write_reg(CFG_TOP, 16'd1);
    send_item(CMD_QUERY_COL, 16'd0, 16'd2, 32'h0);
    write_reg(CFG_TOP, 16'h0110);
    send_item(CMD_QUERY_ROW, 16'd1, 16'd0, 32'h0);
  endtask

  task automatic test_random_traffic();
    int               phase, step, choice;
    logic [KEY_W-1:0] span_r, span_c;
    for (phase = 0; phase < 4; phase++) begin
      quiet = (phase == 2);
      write_reg(CFG_ROWS, (phase == 3) ? 16'hFFFF : KEY_W'($urandom_range(4, 14)));
      write_reg(CFG_COLUMNS, (phase == 1) ? 16'hFFFF : KEY_W'($urandom_range(4, 14)));
      case (phase)
        0:       write_reg(CFG_TOP, KEY_W'($urandom_range(1, MAX_TOP)));
        1:       write_reg(CFG_TOP, KEY_W'(MAX_TOP));
        2:       write_reg(CFG_TOP, KEY_W'($urandom_range(1, 4)));
        default: write_reg(CFG_TOP, KEY_W'($urandom_range(MAX_TOP + 1, 31)));
      endcase
      span_r = (max_row < 14) ? max_row + 16'd1 : 16'd14;
      span_c = (max_col < 14) ? max_col + 16'd1 : 16'd14;
      for (step = 0; step < 45; step++) begin
        choice = $urandom_range(0, 99);
        if (choice < 45)
          send_item(CMD_PUT, KEY_W'($urandom_range(1, span_r)),
                    KEY_W'($urandom_range(1, span_c)), tie_prone_value());
        else if (choice < 70)
          send_item(CMD_QUERY_ROW, KEY_W'($urandom_range(1, span_r)), KEY_W'($urandom),
                    $urandom);
        else if (choice < 90)
          send_item(CMD_QUERY_COL, KEY_W'($urandom), KEY_W'($urandom_range(1, span_c)),
                    $urandom);
        else
          send_item(2'($urandom_range(0, 3)), KEY_W'($urandom), KEY_W'($urandom), $urandom);
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_wide_keys();
    int step;
    write_reg(CFG_ROWS, 16'hFFFF);
    write_reg(CFG_COLUMNS, 16'hFFFF);
    write_reg(CFG_TOP, KEY_W'(MAX_TOP));
    for (step = 0; step < 12; step++)
      send_item(CMD_PUT, KEY_W'($urandom_range(1, 8)), KEY_W'($urandom_range(1, 65535)),
                $urandom);
    send_item(CMD_PUT, 16'd9, 16'd9, 32'h1234_5678);
    send_item(CMD_PUT, store_row[0], store_col[0], $urandom);
    send_item(CMD_PUT, 16'd0, 16'd9, 32'h0);
    send_item(CMD_QUERY_ROW, 16'd1, KEY_W'($urandom), $urandom);
    send_item(CMD_QUERY_ROW, store_row[7], KEY_W'($urandom), $urandom);
    send_item(CMD_QUERY_COL, KEY_W'($urandom), store_col[5], $urandom);
    send_item(CMD_QUERY_ROW, 16'd9, KEY_W'($urandom), $urandom);
    write_reg(CFG_TOP, 16'd1);
    send_item(CMD_QUERY_ROW, 16'd2, KEY_W'($urandom), $urandom);
  endtask

  task automatic finish_run();
    wait_drained();
    cfg_valid <= 1'b0;
    repeat (SETTLE) @(posedge clk);
    if (owed_answers.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected results never arrived", $time, owed_answers.size());
    end
    $display("Sent %0d items through directed, random and wide-key tests with %0d register",
             items_sent, reg_writes);
    $display("writes; checked %0d results, store reached %0d of %0d entries, %0d mismatches.",
             answers_checked, stored_count, CAPACITY, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  endtask

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    command      = CMD_PUT;
    row_index    = '0;
    column_index = '0;
    put_value    = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_ROWS;
    cfg_data     = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_empty_and_errors();
    test_put_and_rank();
    test_register_limits();
    test_top_count_bounds();
    test_random_traffic();
    test_wide_keys();
    finish_run();
  end

endmodule
